>>> design/pnpl_pkg.sv
// Shared types and constants for the path nearest point and lookahead block.
// Holds field widths, register and request codes, the sequencer state type and
// the waypoint and squared distance structs used by every module.
package pnpl_pkg;

    localparam int COORD_W        = 32;
    localparam int IDX_W          = 10;
    localparam int CFG_W          = 11;
    localparam int LOOK_W         = 32;
    localparam int SQ_W           = 64;
    localparam int ROOT_W         = 32;
    localparam int DEF_PATH_DEPTH = 1024;
    localparam int IN_TDATA_W     = 112;
    localparam int OUT_TDATA_W    = 24;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int REG_SEL_W      = 1;

    // Register selects (paddr above the byte offset).
    localparam logic [REG_SEL_W-1:0] REG_PATH_POINTS = 1'b0;
    localparam logic [CFG_W-1:0]     PATH_POINTS_RST = 11'd1;

    // Request kinds carried in tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic            valid;
        logic            hi;
        logic [SQ_W-1:0] lo;
    } sq_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_WSTART,
        S_WPREV,
        S_WCHECK,
        S_WSEG,
        S_WSQ,
        S_WROOT,
        S_DONE
    } seq_state_t;

endpackage

>>> design/path_nearest_point_lookahead.sv
// Top level: waypoint store with nearest point search and lookahead walk.
// Operation: a write word is stored at its accept edge; a query scans n points for the nearest one,
// then walks forward summing segment lengths, each from a 32-step square root. After a query, the
// next word is taken once its result sits in the output register: one word at a time.
// Reset: rst_n clears control state and sets path_points to 1; waypoints are not cleared.
module path_nearest_point_lookahead #(
    parameter int PATH_DEPTH = pnpl_pkg::DEF_PATH_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_index[9:0], pos_x[41:10], pos_y[73:42], lookahead[105:74], zero pad
    input  logic [pnpl_pkg::IN_TDATA_W-1:0]     s_tdata,
    // req_type
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // nearest_index[9:0], preview_index[19:10], zero pad
    output logic [pnpl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pnpl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pnpl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pnpl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import pnpl_pkg::*;

    localparam int AW    = $clog2(PATH_DEPTH);
    localparam int CW    = (AW + 1 > CFG_W + 1) ? AW + 1 : CFG_W + 1;
    localparam int X_LSB = IDX_W;
    localparam int Y_LSB = IDX_W + COORD_W;
    localparam int L_LSB = IDX_W + 2 * COORD_W;

    logic [CFG_W-1:0]     path_points_reg;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 cfg_wr;
    logic [CW-1:0]        pp_ext, n_eff, idx_ext;
    logic                 wr_en, rd_en;
    logic [AW-1:0]        rd_addr;
    point_t               in_pos, rd_data;
    logic [IDX_W-1:0]     nearest, preview;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == REG_PATH_POINTS) ? APB_DATA_W'(path_points_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_points_reg <= PATH_POINTS_RST;
        end
        else if (cfg_wr && (reg_sel == REG_PATH_POINTS))
        begin
            path_points_reg <= pwdata[CFG_W-1:0];
        end
    end

    // A path length of zero acts as one point, and anything past the memory as all of it.
    always_comb
    begin
        pp_ext = CW'(path_points_reg);
        if (pp_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (pp_ext > CW'(PATH_DEPTH))
        begin
            n_eff = CW'(PATH_DEPTH);
        end
        else
        begin
            n_eff = pp_ext;
        end
    end

    assign in_pos.x = s_tdata[X_LSB +: COORD_W];
    assign in_pos.y = s_tdata[Y_LSB +: COORD_W];
    assign idx_ext  = CW'(s_tdata[IDX_W-1:0]);
    assign wr_en    = s_tvalid && s_tready && (s_tuser == REQ_WRITE)
                   && (idx_ext < CW'(PATH_DEPTH));

    pnpl_wpt_mem #(.DEPTH(PATH_DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (in_pos),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pnpl_seq #(.PATH_DEPTH(PATH_DEPTH)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .n_eff       (n_eff),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_type     (s_tuser),
        .in_pos      (in_pos),
        .in_look     (s_tdata[L_LSB +: LOOK_W]),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_nearest (nearest),
        .out_preview (preview)
    );

    assign m_tdata = {{(OUT_TDATA_W - 2 * IDX_W){1'b0}}, preview, nearest};

endmodule

>>> design/pnpl_wpt_mem.sv
// Waypoint memory: one write port, one read port with registered read data.
// Depends on pnpl_pkg for the waypoint type.
module pnpl_wpt_mem #(
    parameter int  DEPTH = pnpl_pkg::DEF_PATH_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  pnpl_pkg::point_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output pnpl_pkg::point_t rd_data
);
    import pnpl_pkg::*;

    point_t wpt_mem [DEPTH];
    point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wpt_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= wpt_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/pnpl_sqdist.sv
// Three-stage squared distance pipeline: magnitudes, squares, 65-bit sum.
// Depends on pnpl_pkg for the waypoint and result types.
module pnpl_sqdist #(
    parameter int TAG_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [TAG_W-1:0]  in_tag,
    input  pnpl_pkg::point_t  a,
    input  pnpl_pkg::point_t  b,
    output pnpl_pkg::sq_res_t res,
    output logic [TAG_W-1:0]  res_tag
);
    import pnpl_pkg::*;

    logic [COORD_W:0]   dx, dy, ndx, ndy;
    logic [COORD_W-1:0] mx_next, my_next;
    logic [COORD_W-1:0] mx_reg, my_reg;
    logic [SQ_W-1:0]    sqx_next, sqy_next;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [SQ_W:0]      sum_next;
    logic [SQ_W:0]      sum_reg;
    logic [2:0]         vld_reg;
    logic [TAG_W-1:0]   tag1_reg, tag2_reg, tag3_reg;

    // The difference of two 32-bit signed values has a magnitude below 2^32.
    always_comb
    begin
        dx      = {a.x[COORD_W-1], a.x} - {b.x[COORD_W-1], b.x};
        dy      = {a.y[COORD_W-1], a.y} - {b.y[COORD_W-1], b.y};
        ndx     = '0 - dx;
        ndy     = '0 - dy;
        mx_next = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        my_next = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
    end

    assign sqx_next = mx_reg * mx_reg;
    assign sqy_next = my_reg * my_reg;
    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        tag1_reg <= in_tag;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        tag2_reg <= tag1_reg;
        sum_reg  <= sum_next;
        tag3_reg <= tag2_reg;
    end

    assign res.valid = vld_reg[2];
    assign res.hi    = sum_reg[SQ_W];
    assign res.lo    = sum_reg[SQ_W-1:0];
    assign res_tag   = tag3_reg;

endmodule

>>> design/pnpl_isqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Depends on pnpl_pkg for the operand and root widths.
module pnpl_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pnpl_pkg::SQ_W-1:0]   radicand,
    output logic                        done,
    output logic [pnpl_pkg::ROOT_W-1:0] root
);
    import pnpl_pkg::*;

    localparam int ITER  = SQ_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SQ_W-1:0]  rem_reg, res_reg, bit_reg;
    logic [SQ_W-1:0]  rem_next, res_next, trial;

    always_comb
    begin
        trial = res_reg + bit_reg;
        if (rem_reg >= trial)
        begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(ITER - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == CNT_W'(ITER - 1)))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

>>> design/pnpl_seq.sv
// Query sequencer: scans the waypoint memory for the nearest point, then walks
// forward summing segment lengths. Depends on pnpl_pkg, pnpl_sqdist, pnpl_isqrt.
module pnpl_seq #(
    parameter int  PATH_DEPTH = pnpl_pkg::DEF_PATH_DEPTH,
    localparam int AW         = $clog2(PATH_DEPTH),
    localparam int CW         = (AW + 1 > pnpl_pkg::CFG_W + 1) ? AW + 1 : pnpl_pkg::CFG_W + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CW-1:0]               n_eff,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_type,
    input  pnpl_pkg::point_t            in_pos,
    input  logic [pnpl_pkg::LOOK_W-1:0] in_look,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  pnpl_pkg::point_t            rd_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pnpl_pkg::IDX_W-1:0]  out_nearest,
    output logic [pnpl_pkg::IDX_W-1:0]  out_preview
);
    import pnpl_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [CW-1:0]     issue_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_tag_reg;
    logic [AW-1:0]     best_reg, prev_reg;
    logic [SQ_W-1:0]   best_lo_reg;
    logic              best_hi_reg;
    point_t            prev_pt_reg, qpos_reg;
    logic [LOOK_W-1:0] look_reg, acc_reg, acc_next, acc_len;
    logic [LOOK_W:0]   acc_sum;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_near_reg, out_prev_reg;

    logic              sq_in_valid;
    point_t            sq_a, sq_b;
    sq_res_t           sq_res;
    logic [AW-1:0]     sq_tag;
    logic              root_start, root_done;
    logic [ROOT_W-1:0] root;

    logic              better, scan_upd, scan_last, walk_go, acc_load, out_load;
    logic [CW-1:0]     prev_plus1, n_last, best_ext, prev_ext;

    pnpl_sqdist #(.TAG_W(AW)) u_sqdist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_in_valid),
        .in_tag   (rd_tag_reg),
        .a        (sq_a),
        .b        (sq_b),
        .res      (sq_res),
        .res_tag  (sq_tag)
    );

    pnpl_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sq_res.lo),
        .done     (root_done),
        .root     (root)
    );

    assign prev_ext   = CW'(prev_reg);
    assign best_ext   = CW'(best_reg);
    assign prev_plus1 = prev_ext + CW'(1);
    assign n_last     = n_eff - CW'(1);
    assign walk_go    = (prev_plus1 < n_eff) && (acc_reg < look_reg);

    // A point that overflows 64 bits loses to any that does not; ties keep the lower index.
    assign better = (sq_tag == '0)
                 || (!sq_res.hi && best_hi_reg)
                 || ((sq_res.hi == best_hi_reg) && (sq_res.lo < best_lo_reg));
    assign scan_last = sq_res.valid && (sq_tag == n_last[AW-1:0]);

    assign acc_sum  = {1'b0, acc_reg} + {1'b0, acc_len};
    assign acc_next = acc_sum[LOOK_W] ? '1 : acc_sum[LOOK_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (in_type == REQ_QUERY))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_WSTART;
                end
            end
            S_WSTART: state_next = S_WPREV;
            S_WPREV:  state_next = S_WCHECK;
            S_WCHECK: state_next = walk_go ? S_WSEG : S_DONE;
            S_WSEG:   state_next = S_WSQ;
            S_WSQ:
            begin
                if (sq_res.valid)
                begin
                    state_next = sq_res.hi ? S_WCHECK : S_WROOT;
                end
            end
            S_WROOT:
            begin
                if (root_done)
                begin
                    state_next = S_WCHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = issue_reg[AW-1:0];
        sq_in_valid = 1'b0;
        sq_a        = qpos_reg;
        sq_b        = rd_data;
        scan_upd    = 1'b0;
        root_start  = 1'b0;
        acc_load    = 1'b0;
        acc_len     = '0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_SCAN:
            begin
                rd_en       = issue_reg < n_eff;
                sq_in_valid = rd_valid_reg;
                scan_upd    = sq_res.valid && better;
            end
            S_WSTART:
            begin
                rd_en   = 1'b1;
                rd_addr = best_reg;
            end
            S_WPREV:  ;
            S_WCHECK:
            begin
                rd_en   = walk_go;
                rd_addr = prev_plus1[AW-1:0];
            end
            S_WSEG:
            begin
                sq_in_valid = 1'b1;
                sq_a        = rd_data;
                sq_b        = prev_pt_reg;
            end
            S_WSQ:
            begin
                if (sq_res.valid)
                begin
                    if (sq_res.hi)
                    begin
                        acc_load = 1'b1;
                        acc_len  = '1;
                    end
                    else
                    begin
                        root_start = 1'b1;
                    end
                end
            end
            S_WROOT:
            begin
                acc_load = root_done;
                acc_len  = LOOK_W'(root);
            end
            S_DONE:   out_load = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag_reg <= rd_addr;
        if (in_valid && in_ready && (in_type == REQ_QUERY))
        begin
            qpos_reg  <= in_pos;
            look_reg  <= in_look;
            issue_reg <= '0;
        end
        else if ((state_reg == S_SCAN) && rd_en)
        begin
            issue_reg <= issue_reg + CW'(1);
        end
        if (scan_upd)
        begin
            best_reg    <= sq_tag;
            best_lo_reg <= sq_res.lo;
            best_hi_reg <= sq_res.hi;
        end
        if (state_reg == S_WSTART)
        begin
            prev_reg <= best_reg;
            acc_reg  <= '0;
        end
        else if (acc_load)
        begin
            prev_reg <= prev_plus1[AW-1:0];
            acc_reg  <= acc_next;
        end
        // The segment pipeline samples the old point in the same cycle it is replaced.
        if ((state_reg == S_WPREV) || (state_reg == S_WSEG))
        begin
            prev_pt_reg <= rd_data;
        end
        if (out_load)
        begin
            out_near_reg <= best_ext[IDX_W-1:0];
            out_prev_reg <= prev_ext[IDX_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_nearest = out_near_reg;
    assign out_preview = out_prev_reg;

    ap_sq_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_res.valid |-> ((state_reg == S_SCAN) || (state_reg == S_WSQ)))
        else $error("squared distance result arrived outside scan or segment wait");

    ap_root_owner: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == S_WROOT))
        else $error("square root finished while no segment waited for it");

    ap_walk_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WCHECK) |-> (prev_reg >= best_reg))
        else $error("walk index fell behind the nearest index");

    ap_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CW'(rd_addr) < n_eff))
        else $error("memory read beyond the path in use");

endmodule
